FILE: design/bcdc_pkg.sv
// ----------------------------------------------------------------------------
// bcdc_pkg
// Shared types, codes and digit helpers for the BCD clock with alarm.
// ----------------------------------------------------------------------------
package bcdc_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_INC  = 2'd1;
    localparam logic [1:0] CMD_DEC  = 2'd2;

    // edit unit codes
    localparam logic [1:0] UNIT_NONE   = 2'd0;
    localparam logic [1:0] UNIT_HOURS  = 2'd1;
    localparam logic [1:0] UNIT_MINS   = 2'd2;
    localparam logic [1:0] UNIT_SECS   = 2'd3;

    // configuration register indexes
    localparam logic CFG_TICKS_PER_SEC = 1'b0;
    localparam logic CFG_RING_LIMIT    = 1'b1;

    localparam logic [15:0] TPS_RESET        = 16'd1000;
    localparam logic [7:0]  RING_LIMIT_RESET = 8'd59;
    localparam logic [7:0]  RING_SEC_MAX     = 8'd255;
    localparam logic [2:0]  LED_LAST         = 3'd7;

    localparam logic [3:0] DIGIT_MAX      = 4'd9;
    localparam logic [3:0] HOUR_TENS_MAX  = 4'd2;
    localparam logic [3:0] HOUR_UNITS_MAX = 4'd3;
    localparam logic [3:0] SIXTY_TENS_MAX = 4'd5;

    localparam int CFG_DATA_W = 16;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 32;

    // HH:MM:SS as BCD digits
    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
    } time_t;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [7:0] led_pattern;
        logic       ringing;
        logic [3:0] second_units;
        logic [2:0] second_tens;
        logic [3:0] minute_units;
        logic [2:0] minute_tens;
        logic [3:0] hour_units;
        logic [1:0] hour_tens;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // input item, command travels separately on tuser
    typedef struct packed {
        logic [1:0] command;
        logic       target;
        logic [1:0] unit;
        logic       setting_time;
        logic       alarm_enable;
        logic       led_show_enable;
    } item_t;

    typedef struct packed {
        logic [15:0] ticks_per_second;
        logic [7:0]  ring_limit_seconds;
    } cfg_t;

    // step a two-digit BCD field up or down, wrapping at {tmax,umax}
    function automatic logic [7:0] bcd_step(input logic [3:0] t, input logic [3:0] u,
                                            input logic up, input logic [3:0] tmax,
                                            input logic [3:0] umax);
        logic [7:0] r;
        if (up) begin
            if (t == tmax && u == umax) r = 8'd0;
            else if (u == DIGIT_MAX)   r = {t + 4'd1, 4'd0};
            else                       r = {t, u + 4'd1};
        end else begin
            if (t == 4'd0 && u == 4'd0) r = {tmax, umax};
            else if (u == 4'd0)         r = {t - 4'd1, DIGIT_MAX};
            else                        r = {t, u - 4'd1};
        end
        return r;
    endfunction

    // apply an increment or decrement to one field of a time
    function automatic time_t edit_time(input time_t tm, input logic [1:0] unit,
                                        input logic up);
        time_t      r;
        logic [7:0] p;
        r = tm;
        unique case (unit)
            UNIT_HOURS: begin
                p = bcd_step({2'b0, tm.hour_tens}, tm.hour_units, up,
                             HOUR_TENS_MAX, HOUR_UNITS_MAX);
                r.hour_tens  = p[5:4];
                r.hour_units = p[3:0];
            end
            UNIT_MINS: begin
                p = bcd_step({1'b0, tm.minute_tens}, tm.minute_units, up,
                             SIXTY_TENS_MAX, DIGIT_MAX);
                r.minute_tens  = p[6:4];
                r.minute_units = p[3:0];
            end
            UNIT_SECS: begin
                p = bcd_step({1'b0, tm.second_tens}, tm.second_units, up,
                             SIXTY_TENS_MAX, DIGIT_MAX);
                r.second_tens  = p[6:4];
                r.second_units = p[3:0];
            end
            default: begin
                p = 8'd0;
            end
        endcase
        return r;
    endfunction

    // advance the clock by one second, carrying into minutes and hours
    function automatic time_t advance_second(input time_t tm);
        time_t r;
        r = edit_time(tm, UNIT_SECS, 1'b1);
        if (tm.second_tens == SIXTY_TENS_MAX[2:0] && tm.second_units == DIGIT_MAX) begin
            r = edit_time(r, UNIT_MINS, 1'b1);
            if (tm.minute_tens == SIXTY_TENS_MAX[2:0] && tm.minute_units == DIGIT_MAX) begin
                r = edit_time(r, UNIT_HOURS, 1'b1);
            end
        end
        return r;
    endfunction

endpackage

FILE: design/bcdc_core.sv
// ----------------------------------------------------------------------------
// bcdc_core
// Clock, alarm and ring state; one word updates it and yields one result.
// ----------------------------------------------------------------------------
module bcdc_core import bcdc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    time_t       clock_reg, clock_next;
    time_t       alarm_reg, alarm_next;
    logic [15:0] tick_reg, tick_next;
    logic [15:0] ring_tick_reg, ring_tick_next;
    logic        ring_reg, ring_next;
    logic [7:0]  ring_sec_reg, ring_sec_next;
    logic [2:0]  led_pos_reg, led_pos_next;
    logic        led_desc_reg, led_desc_next;
    time_t       shown;

    // next state for the word at the input
    always_comb begin
        clock_next     = clock_reg;
        alarm_next     = alarm_reg;
        tick_next      = tick_reg;
        ring_tick_next = ring_tick_reg;
        ring_next      = ring_reg;
        ring_sec_next  = ring_sec_reg;
        led_pos_next   = led_pos_reg;
        led_desc_next  = led_desc_reg;

        if (item.command == CMD_TICK) begin
            // time base
            if (!item.setting_time) begin
                if (tick_reg >= cfg.ticks_per_second) begin
                    clock_next = advance_second(clock_reg);
                    tick_next  = 16'd0;
                end else begin
                    tick_next = tick_reg + 16'd1;
                end
            end
            // ring second counter and LED bounce
            if (ring_reg) begin
                if (ring_tick_reg >= cfg.ticks_per_second) begin
                    if (ring_sec_reg != RING_SEC_MAX) ring_sec_next = ring_sec_reg + 8'd1;
                    if (item.led_show_enable) begin
                        if (!led_desc_reg) begin
                            led_pos_next = led_pos_reg + 3'd1;
                            if (led_pos_next == LED_LAST) led_desc_next = 1'b1;
                        end else begin
                            led_pos_next = led_pos_reg - 3'd1;
                            if (led_pos_next == 3'd0) led_desc_next = 1'b0;
                        end
                    end
                    ring_tick_next = 16'd0;
                end else begin
                    ring_tick_next = ring_tick_reg + 16'd1;
                end
            end
        end else if ((item.command == CMD_INC || item.command == CMD_DEC) &&
                     item.unit != UNIT_NONE) begin
            if (item.target) alarm_next = edit_time(alarm_reg, item.unit, item.command == CMD_INC);
            else             clock_next = edit_time(clock_reg, item.unit, item.command == CMD_INC);
        end

        // stop, then start
        if (ring_next && (!item.alarm_enable || ring_sec_next > cfg.ring_limit_seconds)) begin
            ring_next      = 1'b0;
            ring_sec_next  = 8'd0;
            ring_tick_next = 16'd0;
        end
        if (item.alarm_enable && !ring_next && clock_next == alarm_next) begin
            ring_next      = 1'b1;
            ring_sec_next  = 8'd0;
            ring_tick_next = 16'd0;
        end
    end

    // result taken after the update
    always_comb begin
        shown               = item.target ? alarm_next : clock_next;
        result.hour_tens    = shown.hour_tens;
        result.hour_units   = shown.hour_units;
        result.minute_tens  = shown.minute_tens;
        result.minute_units = shown.minute_units;
        result.second_tens  = shown.second_tens;
        result.second_units = shown.second_units;
        result.ringing      = ring_next;
        result.led_pattern  = ring_next ? (8'd1 << led_pos_next) : 8'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg     <= '0;
            alarm_reg     <= '0;
            tick_reg      <= '0;
            ring_tick_reg <= '0;
            ring_reg      <= 1'b0;
            ring_sec_reg  <= '0;
            led_pos_reg   <= '0;
            led_desc_reg  <= 1'b0;
        end else if (push) begin
            clock_reg     <= clock_next;
            alarm_reg     <= alarm_next;
            tick_reg      <= tick_next;
            ring_tick_reg <= ring_tick_next;
            ring_reg      <= ring_next;
            ring_sec_reg  <= ring_sec_next;
            led_pos_reg   <= led_pos_next;
            led_desc_reg  <= led_desc_next;
        end
    end

endmodule

FILE: design/bcdc_skid.sv
// ----------------------------------------------------------------------------
// bcdc_skid
// Output register with one skid entry so the input can take one more word under stall.
// ----------------------------------------------------------------------------
module bcdc_skid import bcdc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    // a push is only possible while the skid entry is empty
    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_data_next  = push_data;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

FILE: design/bcd_clock_with_alarm_top.sv
// ----------------------------------------------------------------------------
// bcd_clock_with_alarm_top
// 24-hour BCD clock with alarm, ring timer and bouncing LED pattern.
// ----------------------------------------------------------------------------
// Each result word is registered onto m_tdata, via the skid entry under stall.
// Throughput: one word per cycle while s_tready is high; the update is a single pass.
// A one-entry skid keeps s_tready high for one word while m_tready is low.
// Reset (aresetn low, synchronous): times, counters and ring state clear,
// ticks_per_second returns to 1000 and ring_limit_seconds to 59.
module bcd_clock_with_alarm_top import bcdc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic                   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // input words
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [0] target, [2:1] unit, [3] setting_time, [4] alarm_enable,
    // [5] led_show_enable, [7:6] zero
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [1:0]             s_tuser,
    // result words
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [1:0] hour_tens, [5:2] hour_units, [8:6] minute_tens, [12:9] minute_units,
    // [15:13] second_tens, [19:16] second_units, [20] ringing,
    // [28:21] led_pattern, [31:29] zero
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    cfg_t    cfg_reg;
    item_t   item;
    result_t result;
    result_t out_word;
    logic    push;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_second   <= TPS_RESET;
            cfg_reg.ring_limit_seconds <= RING_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_TICKS_PER_SEC: cfg_reg.ticks_per_second   <= cfg_wr_data;
                CFG_RING_LIMIT:    cfg_reg.ring_limit_seconds <= cfg_wr_data[7:0];
                default:           cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // unpack the input word
    always_comb begin
        item.command         = s_tuser;
        item.target          = s_tdata[0];
        item.unit            = s_tdata[2:1];
        item.setting_time    = s_tdata[3];
        item.alarm_enable    = s_tdata[4];
        item.led_show_enable = s_tdata[5];
    end

    assign push = s_tvalid && s_tready;

    bcdc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    bcdc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (result),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = {{(TDATA_OUT_W-RESULT_W){1'b0}}, out_word};

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BCD clock with alarm. A short table of directed
// words is followed by random phases under different register settings; every
// result word is checked against the table for typed rows, else against a
// cycle-free model of the clock, alarm and ring logic kept in this bench.
// ----------------------------------------------------------------------------
module tb_top;
    import bcdc_pkg::*;

    // command code with no function; the block still answers it
    localparam logic [1:0] CMD_NONE = 2'd3;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic                   cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;

    bcd_clock_with_alarm_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // model state: fields are 0 hours, 1 minutes, 2 seconds
    int  clk_f [3];
    int  alm_f [3];
    int  tick_cnt;
    int  ring_tick_cnt;
    int  ring_secs;
    int  led_pos;
    bit  ring_on;
    bit  led_down;
    int  tps_reg;
    int  limit_reg;

    result_t expected_display [$];
    int      mismatch_count;
    bit      steady;    // no idling on either side while set
    bit      armed;     // alarm_enable level used by the random words

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } step_row_t;

    step_row_t step_rows [$];

    // random phases: tick rate, ring limit, word count, tick share, arm toggle rate
    int ph_tps   [5] = '{1, 2, 1, 65535, 4};
    int ph_limit [5] = '{1, 20, 255, 255, 59};
    int ph_words [5] = '{200, 200, 800, 40, 100};
    int ph_ticks [5] = '{60, 60, 85, 60, 60};
    int ph_flip  [5] = '{30, 30, 0, 20, 20};

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2000000;
        $display("tb_top: done, errors");
        $finish;
    end

    // apply one word to the model, return the word it shows afterwards
    function automatic result_t predict_display(input item_t it);
        result_t r;
        int      idx;
        int      fmod;
        int      stp;
        int      sel [3];
        if (it.command == CMD_TICK) begin
            if (!it.setting_time) begin
                if (tick_cnt + 1 > tps_reg) begin
                    tick_cnt = 0;
                    clk_f[2] = clk_f[2] + 1;
                    if (clk_f[2] == 60) begin
                        clk_f[2] = 0;
                        clk_f[1] = clk_f[1] + 1;
                        if (clk_f[1] == 60) begin
                            clk_f[1] = 0;
                            clk_f[0] = (clk_f[0] + 1) % 24;
                        end
                    end
                end else begin
                    tick_cnt = tick_cnt + 1;
                end
            end
            // ring timer runs even while the clock is held
            if (ring_on) begin
                if (ring_tick_cnt + 1 > tps_reg) begin
                    ring_tick_cnt = 0;
                    if (ring_secs < 255) ring_secs = ring_secs + 1;
                    if (it.led_show_enable) begin
                        if (!led_down) begin
                            led_pos = (led_pos + 1) % 8;
                            if (led_pos == 7) led_down = 1'b1;
                        end else begin
                            led_pos = (led_pos + 7) % 8;
                            if (led_pos == 0) led_down = 1'b0;
                        end
                    end
                end else begin
                    ring_tick_cnt = ring_tick_cnt + 1;
                end
            end
        end else if ((it.command == CMD_INC || it.command == CMD_DEC) &&
                     it.unit != UNIT_NONE) begin
            // edits wrap within the field, no carry
            idx  = (it.unit == UNIT_HOURS) ? 0 : (it.unit == UNIT_MINS) ? 1 : 2;
            fmod = (idx == 0) ? 24 : 60;
            stp  = (it.command == CMD_INC) ? 1 : fmod - 1;
            if (it.target) alm_f[idx] = (alm_f[idx] + stp) % fmod;
            else           clk_f[idx] = (clk_f[idx] + stp) % fmod;
        end

        // stop, then possibly start again in the same word
        if (ring_on && (!it.alarm_enable || ring_secs > limit_reg)) begin
            ring_on       = 1'b0;
            ring_secs     = 0;
            ring_tick_cnt = 0;
        end
        if (it.alarm_enable && !ring_on && clk_f == alm_f) begin
            ring_on       = 1'b1;
            ring_secs     = 0;
            ring_tick_cnt = 0;
        end

        if (it.target) sel = alm_f;
        else           sel = clk_f;
        r.hour_tens    = 2'(sel[0] / 10);
        r.hour_units   = 4'(sel[0] % 10);
        r.minute_tens  = 3'(sel[1] / 10);
        r.minute_units = 4'(sel[1] % 10);
        r.second_tens  = 3'(sel[2] / 10);
        r.second_units = 4'(sel[2] % 10);
        r.ringing      = ring_on;
        r.led_pattern  = ring_on ? 8'(1 << led_pos) : 8'd0;
        return r;
    endfunction

    // random word; a share of edits walks the alarm toward the clock time
    function automatic item_t next_random_item(input int tick_pct, input int flip_pm);
        item_t it;
        int    roll;
        int    total;
        int    goal [3];
        int    fmod;
        int    diff;
        bit    found;
        if ($urandom_range(999) < flip_pm) armed = !armed;
        it.alarm_enable    = armed;
        it.setting_time    = ($urandom_range(99) < 15);
        it.led_show_enable = ($urandom_range(99) < 75);
        it.target          = 1'($urandom_range(1));
        it.unit            = 2'($urandom_range(3));
        it.command         = CMD_TICK;
        roll = $urandom_range(99);
        if (roll < tick_pct) begin
            it.command = CMD_TICK;
        end else if (roll < tick_pct + (100 - tick_pct) * 6 / 10) begin
            total = (clk_f[0] * 3600 + clk_f[1] * 60 + clk_f[2] + $urandom_range(3)) % 86400;
            goal[0] = total / 3600;
            goal[1] = (total / 60) % 60;
            goal[2] = total % 60;
            found = 1'b0;
            for (int k = 0; k < 3; k++) begin
                if (!found && alm_f[k] != goal[k]) begin
                    found = 1'b1;
                    fmod  = (k == 0) ? 24 : 60;
                    diff  = (goal[k] - alm_f[k] + fmod) % fmod;
                    it.command = (diff <= fmod / 2) ? CMD_INC : CMD_DEC;
                    it.target  = 1'b1;
                    case (k)
                        0: begin
                            it.unit = UNIT_HOURS;
                        end
                        1: begin
                            it.unit = UNIT_MINS;
                        end
                        default: begin
                            it.unit = UNIT_SECS;
                        end
                    endcase
                end
            end
        end else if (roll < 97) begin
            it.command = $urandom_range(1) ? CMD_INC : CMD_DEC;
        end else begin
            it.command = CMD_NONE;
        end
        return it;
    endfunction

    task automatic add_row(input logic [1:0] cmd, input bit tgt, input logic [1:0] fld,
                           input bit set, input bit en, input bit show, input bit typed,
                           input int h, input int m, input int s, input bit ring,
                           input logic [7:0] led);
        step_row_t row;
        row.it.command             = cmd;
        row.it.target              = tgt;
        row.it.unit                = fld;
        row.it.setting_time        = set;
        row.it.alarm_enable        = en;
        row.it.led_show_enable     = show;
        row.typed                  = typed;
        row.want.hour_tens         = 2'(h / 10);
        row.want.hour_units        = 4'(h % 10);
        row.want.minute_tens       = 3'(m / 10);
        row.want.minute_units      = 4'(m % 10);
        row.want.second_tens       = 3'(s / 10);
        row.want.second_units      = 4'(s % 10);
        row.want.ringing           = ring;
        row.want.led_pattern       = led;
        step_rows.push_back(row);
    endtask

    // drive one word, wait for the handshake, queue what it should show
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        result_t predicted;
        while (!steady && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.led_show_enable, it.alarm_enable, it.setting_time,
                     it.unit, it.target};
        s_tuser  <= it.command;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_display(it);
        expected_display.push_back(typed ? want : predicted);
    endtask

    task automatic write_register(input logic idx, input int value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= CFG_DATA_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
        if (idx == CFG_TICKS_PER_SEC) tps_reg = value & 16'hFFFF;
        else                          limit_reg = value & 8'hFF;
    endtask

    // sink: random backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 33);
        end
    end

    // check each accepted result word against the oldest expectation
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        bit      bad;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (expected_display.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("%0t: result word with nothing expected: %h", $realtime, m_tdata);
            end else begin
                want = expected_display.pop_front();
                bad  = (got.hour_tens    !== want.hour_tens)    ||
                       (got.hour_units   !== want.hour_units)   ||
                       (got.minute_tens  !== want.minute_tens)  ||
                       (got.minute_units !== want.minute_units) ||
                       (got.second_tens  !== want.second_tens)  ||
                       (got.second_units !== want.second_units) ||
                       (got.ringing      !== want.ringing)      ||
                       (got.led_pattern  !== want.led_pattern)  ||
                       (m_tdata[TDATA_OUT_W-1:RESULT_W] !== '0);
                if (bad) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10) begin
                        $write("%0t: mismatch want %0d%0d:%0d%0d:%0d%0d ring %0b led %h,",
                               $realtime,
                               want.hour_tens, want.hour_units, want.minute_tens,
                               want.minute_units, want.second_tens, want.second_units,
                               want.ringing, want.led_pattern);
                        $display(" got %0d%0d:%0d%0d:%0d%0d ring %0b led %h (word %h)",
                                 got.hour_tens, got.hour_units, got.minute_tens,
                                 got.minute_units, got.second_tens, got.second_units,
                                 got.ringing, got.led_pattern, m_tdata);
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        item_t   it;
        result_t none;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = CFG_TICKS_PER_SEC;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_TICK;
        mismatch_count = 0;
        steady         = 1'b0;
        armed          = 1'b1;
        none           = '0;
        clk_f          = '{0, 0, 0};
        alm_f          = '{0, 0, 0};
        tick_cnt       = 0;
        ring_tick_cnt  = 0;
        ring_secs      = 0;
        led_pos        = 0;
        ring_on        = 1'b0;
        led_down       = 1'b0;
        tps_reg        = TPS_RESET;
        limit_reg      = RING_LIMIT_RESET;

        // ring at reset match, stop on disable, field wraps both ways,
        // unit none, unused command, edits while the clock is held
        add_row(CMD_TICK, 0, UNIT_NONE,  0, 1, 1, 1,  0,  0,  0, 1, 8'h01);
        add_row(CMD_TICK, 0, UNIT_NONE,  1, 0, 0, 1,  0,  0,  0, 0, 8'h00);
        add_row(CMD_DEC,  0, UNIT_HOURS, 0, 0, 0, 1, 23,  0,  0, 0, 8'h00);
        add_row(CMD_INC,  0, UNIT_HOURS, 0, 0, 0, 1,  0,  0,  0, 0, 8'h00);
        add_row(CMD_DEC,  0, UNIT_MINS,  1, 0, 0, 1,  0, 59,  0, 0, 8'h00);
        add_row(CMD_DEC,  0, UNIT_SECS,  0, 0, 0, 1,  0, 59, 59, 0, 8'h00);
        add_row(CMD_INC,  0, UNIT_SECS,  0, 0, 0, 1,  0, 59,  0, 0, 8'h00);
        add_row(CMD_INC,  0, UNIT_MINS,  0, 0, 0, 1,  0,  0,  0, 0, 8'h00);
        add_row(CMD_INC,  1, UNIT_NONE,  0, 0, 0, 1,  0,  0,  0, 0, 8'h00);
        add_row(CMD_NONE, 1, UNIT_SECS,  0, 0, 0, 1,  0,  0,  0, 0, 8'h00);
        add_row(CMD_DEC,  1, UNIT_HOURS, 0, 0, 1, 1, 23,  0,  0, 0, 8'h00);
        // alarm digits across the tens boundaries
        add_row(CMD_DEC,  1, UNIT_SECS,  0, 0, 1, 0,  0,  0,  0, 0, 8'h00);
        add_row(CMD_DEC,  1, UNIT_MINS,  0, 0, 1, 0,  0,  0,  0, 0, 8'h00);
        add_row(CMD_DEC,  1, UNIT_HOURS, 0, 0, 0, 0,  0,  0,  0, 0, 8'h00);
        add_row(CMD_DEC,  1, UNIT_HOURS, 0, 0, 0, 0,  0,  0,  0, 0, 8'h00);
        add_row(CMD_DEC,  1, UNIT_HOURS, 0, 0, 0, 0,  0,  0,  0, 0, 8'h00);
        add_row(CMD_DEC,  1, UNIT_HOURS, 0, 0, 0, 0,  0,  0,  0, 0, 8'h00);
        add_row(CMD_INC,  1, UNIT_HOURS, 0, 0, 0, 0,  0,  0,  0, 0, 8'h00);
        add_row(CMD_TICK, 0, UNIT_NONE,  1, 1, 1, 0,  0,  0,  0, 0, 8'h00);
        add_row(CMD_TICK, 1, UNIT_SECS,  1, 1, 1, 0,  0,  0,  0, 0, 8'h00);
        add_row(CMD_INC,  0, UNIT_SECS,  0, 0, 0, 0,  0,  0,  0, 0, 8'h00);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (step_rows[i])
            send_item(step_rows[i].it, step_rows[i].typed, step_rows[i].want);

        // random phases; registers change only once the block has drained
        for (int p = 0; p < 5; p++) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (expected_display.size() != 0) @(posedge aclk);
            write_register(CFG_TICKS_PER_SEC, ph_tps[p]);
            write_register(CFG_RING_LIMIT, ph_limit[p]);
            steady = (p == 1);
            armed  = 1'b1;
            repeat (ph_words[p]) begin
                it = next_random_item(ph_ticks[p], ph_flip[p]);
                send_item(it, 1'b0, none);
            end
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        while (expected_display.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (mismatch_count == 0 && expected_display.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/bcdc_pkg.sv
design/bcdc_core.sv
design/bcdc_skid.sv
design/bcd_clock_with_alarm_top.sv
bench/tb_top.sv
